// ===== hw/rtl/acs_pkg.sv =====
// Package for the audio container sniffer: format codes, magic numbers,
// shared structs and the header classifier function.
// No dependencies; imported by acs_tag_walker and audio_container_sniffer_unit.
`timescale 1ns / 1ps

package acs_pkg;

    typedef enum logic [3:0] {
        FMT_UNKNOWN = 4'd0,
        FMT_WAV     = 4'd1,
        FMT_FLAC    = 4'd2,
        FMT_OGG     = 4'd3,
        FMT_AIFF    = 4'd4,
        FMT_M4A     = 4'd5,
        FMT_MP3     = 4'd6,
        FMT_AAC     = 4'd7,
        CLS_ID3     = 4'd8
    } t_fmt;

    typedef enum logic [1:0] {
        PH_HEAD = 2'd0,
        PH_WALK = 2'd1,
        PH_WAIT = 2'd2
    } t_phase;

    localparam logic [3:0] DECL_AUTO = 4'd0;
    localparam logic [3:0] DECL_OGG  = 4'd3;
    localparam logic [3:0] DECL_OPUS = 4'd8;

    localparam logic [31:0] MAGIC_RIFF = "RIFF";
    localparam logic [31:0] MAGIC_FLAC = "fLaC";
    localparam logic [31:0] MAGIC_OGGS = "OggS";
    localparam logic [31:0] MAGIC_FORM = "FORM";
    localparam logic [31:0] MAGIC_AIFF = "AIFF";
    localparam logic [31:0] MAGIC_AIFC = "AIFC";
    localparam logic [31:0] MAGIC_FTYP = "ftyp";
    localparam logic [23:0] MAGIC_ID3  = "ID3";

    localparam logic [7:0] SYNC_BYTE     = 8'hff;
    localparam logic [7:0] ADTS_MASK     = 8'hf6;
    localparam logic [7:0] ADTS_VALUE    = 8'hf0;
    localparam logic [7:0] MPEG_MASK     = 8'he0;
    localparam logic [7:0] MPEG_LAYER    = 8'h06;
    localparam logic [7:0] SYNCSAFE_MASK = 8'h80;

    // Header bytes the classifier looks at
    localparam int unsigned CLS_BYTES = 12;
    // ID3v2 tag header length, and the extra footer length
    localparam int unsigned TAG_HDR_BYTES = 10;
    localparam logic [28:0] TAG_FOOTER    = 29'd10;

    typedef logic [CLS_BYTES-1:0][7:0] t_hdr_view;

    typedef struct packed {
        logic step;     // walker consumes the byte this cycle
        logic restart;  // byte is the first of a file
        logic last;     // byte is the last of the file
    } t_walk_ctrl;

    typedef struct packed {
        logic hit;      // walk finished with this byte (or earlier)
        t_fmt fmt;
    } t_walk_res;

    // First match wins; ge* say whether the file holds that many bytes.
    function automatic t_fmt classify(input t_hdr_view b, input logic ge2,
                                      input logic ge3, input logic ge4,
                                      input logic ge12);
        logic [31:0] w0;
        logic [31:0] w1;
        logic [31:0] w2;
        t_fmt        f;
        w0 = {b[0], b[1], b[2], b[3]};
        w1 = {b[4], b[5], b[6], b[7]};
        w2 = {b[8], b[9], b[10], b[11]};
        f  = FMT_UNKNOWN;
        if (ge4 && w0 == MAGIC_RIFF) begin
            f = FMT_WAV;
        end else if (ge4 && w0 == MAGIC_FLAC) begin
            f = FMT_FLAC;
        end else if (ge4 && w0 == MAGIC_OGGS) begin
            f = FMT_OGG;
        end else if (ge12 && w0 == MAGIC_FORM &&
                     (w2 == MAGIC_AIFF || w2 == MAGIC_AIFC)) begin
            f = FMT_AIFF;
        end else if (ge12 && w1 == MAGIC_FTYP) begin
            f = FMT_M4A;
        end else if (ge3 && w0[31:8] == MAGIC_ID3) begin
            f = CLS_ID3;
        end else if (ge2 && b[0] == SYNC_BYTE && (b[1] & ADTS_MASK) == ADTS_VALUE) begin
            f = FMT_AAC;
        end else if (ge2 && b[0] == SYNC_BYTE && (b[1] & MPEG_MASK) == MPEG_MASK &&
                     (b[1] & MPEG_LAYER) != 8'd0) begin
            f = FMT_MP3;
        end
        return f;
    endfunction

endpackage

// ===== hw/rtl/audio_container_sniffer_unit.sv =====
// Top level of the audio container sniffer: input register, header
// classifier, ID3v2 tag walk, and result register. Depends on acs_pkg and
// acs_tag_walker.
`timescale 1ns / 1ps

// Feed a file one byte per transfer, with i_is_last high on its final byte.
// The unit takes one byte every cycle: each byte passes an input register and
// one stage of compare-and-count logic, and a result is loaded into the result
// register as the deciding byte leaves the input register. The input side
// stalls only while the result register is full and the output side stalls.
// The first HEADER_BYTES bytes (or the whole file, if shorter) are gathered
// and classified: RIFF, fLaC, OggS, FORM/AIFF or AIFC, ftyp at offset 4, ID3,
// ADTS sync, MPEG sync, in that priority. ID3 files go through a tag walk
// that runs alongside the header from byte zero, skipping chained ID3v2 tags
// (synchsafe size, plus 10 bytes when the footer flag is set); the bytes after
// the last tag decide FLAC ("fLaC") or MP3. Exactly one result transfer is
// made per file; bytes after the result up to the last one are dropped.
// i_cfg_wr_data sets the declared format (0 auto ... 8 opus); write it only
// while the unit is idle. o_declared_ok flags a match, with Ogg also matching
// a declared Opus.
module audio_container_sniffer_unit #(
    parameter int unsigned HEADER_BYTES = 12
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [3:0] i_cfg_wr_data,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_is_last,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [2:0] o_format_code,
    output logic       o_declared_ok
);
    import acs_pkg::*;

    localparam int unsigned POS_W = $clog2(HEADER_BYTES + 1);
    localparam int unsigned IDX_W = $clog2(HEADER_BYTES);

    // Configuration
    logic [3:0] r_declared_format;

    // Input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // Control state
    t_phase     r_phase, n_phase;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [7:0] r_hdr [HEADER_BYTES];

    // Result register
    logic       r_out_valid;
    logic [2:0] r_out_fmt;
    logic       r_out_ok;

    logic       advance, fire, in_take, load_out;
    logic [POS_W-1:0] n_cnt;
    logic       hdr_done;
    t_hdr_view  hv;
    t_fmt       cls, out_fmt;
    logic       out_ok;
    t_walk_ctrl walk_ctrl;
    t_walk_res  walk_res;

    // Handshake: hold a byte in the input register while the result
    // register is full and stalled.
    assign advance = !r_out_valid || !i_stall;
    assign fire    = r_in_valid && advance;
    assign o_stall = r_in_valid && !advance;
    assign in_take = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_declared_format <= DECL_AUTO;
        end else if (i_cfg_wr_en) begin
            r_declared_format <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_is_last;
        end
    end

    // Header view with the current byte dropped into its slot
    always_comb begin
        for (int i = 0; i < CLS_BYTES; i++) begin
            hv[i] = (r_pos == POS_W'(i)) ? r_in_byte : r_hdr[i];
        end
    end

    assign n_cnt    = r_pos + POS_W'(1);
    assign hdr_done = (n_cnt == POS_W'(HEADER_BYTES)) || r_in_last;
    assign cls      = classify(hv, n_cnt >= POS_W'(2), n_cnt >= POS_W'(3),
                               n_cnt >= POS_W'(4), n_cnt >= POS_W'(CLS_BYTES));

    // The tag walk runs on every byte of the file from byte zero, so by the
    // end of the header it already stands where a replay would leave it.
    assign walk_ctrl.step    = fire && (r_phase != PH_WAIT);
    assign walk_ctrl.restart = (r_phase == PH_HEAD) && (r_pos == '0);
    assign walk_ctrl.last    = r_in_last;

    acs_tag_walker u_walker (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (walk_ctrl),
        .i_data  (r_in_byte),
        .o_res   (walk_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEAD;
            r_pos   <= '0;
        end else begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && r_phase == PH_HEAD && !hdr_done) begin
            r_hdr[r_pos[IDX_W-1:0]] <= r_in_byte;
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_pos    = r_pos;
        load_out = 1'b0;
        out_fmt  = FMT_UNKNOWN;
        if (fire) begin
            unique case (r_phase)
                PH_HEAD: begin
                    if (!hdr_done) begin
                        n_pos = n_cnt;
                    end else begin
                        n_pos = '0;
                        if (cls != CLS_ID3) begin
                            load_out = 1'b1;
                            out_fmt  = cls;
                        end else if (walk_res.hit) begin
                            load_out = 1'b1;
                            out_fmt  = walk_res.fmt;
                        end else begin
                            n_phase = PH_WALK;
                        end
                    end
                end
                PH_WALK: begin
                    if (walk_res.hit) begin
                        load_out = 1'b1;
                        out_fmt  = walk_res.fmt;
                    end
                end
                PH_WAIT: begin
                    // drop bytes until the end of the file
                    if (r_in_last) begin
                        n_phase = PH_HEAD;
                        n_pos   = '0;
                    end
                end
                default: begin
                    n_phase = PH_HEAD;
                    n_pos   = '0;
                end
            endcase
            if (load_out) begin
                n_phase = r_in_last ? PH_HEAD : PH_WAIT;
                n_pos   = '0;
            end
        end
    end

    always_comb begin
        if (r_declared_format == DECL_AUTO) begin
            out_ok = 1'b1;
        end else if (out_fmt == FMT_OGG) begin
            out_ok = (r_declared_format == DECL_OGG) || (r_declared_format == DECL_OPUS);
        end else begin
            out_ok = (r_declared_format == 4'(out_fmt));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_fmt <= out_fmt[2:0];
            r_out_ok  <= out_ok;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_format_code = r_out_fmt;
    assign o_declared_ok = r_out_ok;

    a_no_result_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |-> r_phase != PH_WAIT)
        else $error("result produced while dropping the rest of a file");

    a_no_id3_code_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |-> out_fmt != CLS_ID3)
        else $error("internal ID3 class leaked to the result");

    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != PH_HEAD |-> r_pos == '0)
        else $error("header position not cleared outside header collection");

    a_wait_after_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out && !r_in_last |=> r_phase == PH_WAIT)
        else $error("no drop phase after a result ahead of the last byte");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_out_valid && i_stall && r_in_valid)
        else $error("input stalled while the result register could take data");

endmodule

// ===== hw/rtl/acs_tag_walker.sv =====
// ID3v2 tag walker: gathers tag headers, skips tag bodies, decides FLAC or MP3.
// Depends on acs_pkg.
`timescale 1ns / 1ps

module acs_tag_walker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  acs_pkg::t_walk_ctrl i_ctrl,
    input  logic [7:0]         i_data,
    output acs_pkg::t_walk_res o_res
);
    import acs_pkg::*;

    logic [3:0]  r_cnt, n_cnt;
    logic        r_skip, n_skip;
    logic [28:0] r_left, n_left;
    logic        r_done;
    t_fmt        r_fmt;
    logic [7:0]  r_tag [TAG_HDR_BYTES];

    logic                         e_done, e_skip;
    logic [3:0]                   e_cnt, cnt_inc;
    logic [TAG_HDR_BYTES-1:0][7:0] v;
    logic [27:0]                  size;
    logic [28:0]                  left_add, left_dec;
    logic                         is_id3, sync_ok, is_flac, hdr_branch;
    logic                         hit;
    t_fmt                         fmt;

    // A new file starts the walk fresh at a tag header
    assign e_done = r_done && !i_ctrl.restart;
    assign e_skip = r_skip && !i_ctrl.restart;
    assign e_cnt  = i_ctrl.restart ? 4'd0 : r_cnt;
    assign cnt_inc = e_cnt + 4'd1;

    always_comb begin
        for (int i = 0; i < TAG_HDR_BYTES; i++) begin
            v[i] = (e_cnt == 4'(i)) ? i_data : r_tag[i];
        end
    end

    assign size     = {v[6][6:0], v[7][6:0], v[8][6:0], v[9][6:0]};
    assign left_add = {1'b0, size} + (v[5][4] ? TAG_FOOTER : 29'd0);
    assign left_dec = r_left - 29'd1;
    assign is_id3   = {v[0], v[1], v[2]} == MAGIC_ID3;
    assign sync_ok  = ((v[6] | v[7] | v[8] | v[9]) & SYNCSAFE_MASK) == 8'd0;
    assign is_flac  = {v[0], v[1], v[2], v[3]} == MAGIC_FLAC;
    assign hdr_branch = !e_done && !e_skip;

    always_comb begin
        n_cnt  = e_cnt;
        n_skip = e_skip;
        n_left = r_left;
        hit    = 1'b0;
        fmt    = FMT_MP3;
        if (e_done) begin
            hit = 1'b1;
            fmt = r_fmt;
        end else if (e_skip) begin
            n_left = left_dec;
            if (left_dec == 29'd0) begin
                n_skip = 1'b0;
                n_cnt  = 4'd0;
            end
            hit = i_ctrl.last;
        end else begin
            n_cnt = cnt_inc;
            if (cnt_inc == 4'(TAG_HDR_BYTES)) begin
                if (is_id3 && sync_ok) begin
                    n_left = left_add;
                    if (left_add == 29'd0) begin
                        n_cnt = 4'd0;
                    end else begin
                        n_skip = 1'b1;
                    end
                    hit = i_ctrl.last;
                end else begin
                    hit = 1'b1;
                    fmt = is_flac ? FMT_FLAC : FMT_MP3;
                end
            end else begin
                hit = i_ctrl.last;
                fmt = (cnt_inc >= 4'd4 && is_flac) ? FMT_FLAC : FMT_MP3;
            end
        end
    end

    assign o_res.hit = hit;
    assign o_res.fmt = fmt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 4'd0;
            r_skip <= 1'b0;
            r_left <= 29'd0;
            r_done <= 1'b0;
            r_fmt  <= FMT_UNKNOWN;
        end else if (i_ctrl.step) begin
            r_cnt  <= n_cnt;
            r_skip <= n_skip;
            r_left <= n_left;
            r_done <= hit;
            r_fmt  <= fmt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.step && hdr_branch && e_cnt < 4'(TAG_HDR_BYTES)) begin
            r_tag[e_cnt] <= i_data;
        end
    end

endmodule
